// File: design/hbac_pkg.sv
// Shared types and constants for the hot block access counter.
// Used by hbac_table, hbac_seq and hot_block_access_counter; no dependencies.
`default_nettype none

package hbac_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int MAX_RESULTS       = 64;
	localparam int RES_W             = $clog2(MAX_RESULTS);
	localparam int KEY_W             = 64;
	localparam int CNT_W             = 32;
	localparam int MODE_W            = 2;
	localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(16);

	typedef enum logic [MODE_W-1:0] {
		MODE_RECORD = 2'd0,
		MODE_REPORT = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_HOT   = 2'd2,
		ST_NOHOT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REC_RD,
		S_REC_CMP,
		S_INS,
		S_SHIFT,
		S_SH_RD,
		S_SH_WR,
		S_REP_RD,
		S_REP_CHK,
		S_CLR,
		S_RESP
	} seq_state_t;

	typedef struct packed {
		status_t            status;
		logic [KEY_W-1:0]   blk;
		logic [CNT_W-1:0]   cnt;
		logic               last;
	} res_t;

	typedef struct packed {
		logic               key_we;
		logic               cnt_we;
		logic [KEY_W-1:0]   key;
		logic [CNT_W-1:0]   cnt;
	} mem_wr_t;

endpackage

`default_nettype wire

// File: design/hbac_table.sv
// Entry store: block numbers and access counts, one write and one read port.
// Read data is registered. Depends on hbac_pkg.
`default_nettype none

module hbac_table #(
	parameter int TABLE_ENTRIES = hbac_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         rd_en,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
	input  wire hbac_pkg::mem_wr_t            wr,
	output logic [hbac_pkg::KEY_W-1:0]        rd_key,
	output logic [hbac_pkg::CNT_W-1:0]        rd_cnt
);

	logic [hbac_pkg::KEY_W-1:0] keys_q [TABLE_ENTRIES];
	logic [hbac_pkg::CNT_W-1:0] cnts_q [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			keys_q[wr_addr] <= wr.key;
		end
		if (wr.cnt_we) begin
			cnts_q[wr_addr] <= wr.cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key <= keys_q[rd_addr];
			rd_cnt <= cnts_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/hbac_seq.sv
// Sequencer with the shared key compare, count compare and increment unit.
// Scans, shifts and clears the entry store. Depends on hbac_pkg.
`default_nettype none

module hbac_seq #(
	parameter int TABLE_ENTRIES = hbac_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [hbac_pkg::MODE_W-1:0]       in_mode,
	input  wire logic [hbac_pkg::KEY_W-1:0]        in_blk,
	input  wire logic [hbac_pkg::CNT_W-1:0]        thresh,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output hbac_pkg::res_t                         res,
	output logic                                   rd_en,
	output logic [$clog2(TABLE_ENTRIES)-1:0]       rd_addr,
	output logic [$clog2(TABLE_ENTRIES)-1:0]       wr_addr,
	output hbac_pkg::mem_wr_t                      wr,
	input  wire logic [hbac_pkg::KEY_W-1:0]        rd_key,
	input  wire logic [hbac_pkg::CNT_W-1:0]        rd_cnt
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

	hbac_pkg::seq_state_t state_q, state_d;
	logic [USED_W-1:0]           used_q, used_d;
	logic [IDX_W-1:0]            i_q, i_d;
	logic [IDX_W-1:0]            j_q, j_d;
	logic [IDX_W-1:0]            pos_q, pos_d;
	logic [hbac_pkg::RES_W-1:0]  fcnt_q, fcnt_d;
	logic                        pend_v_q, pend_v_d;
	logic [hbac_pkg::KEY_W-1:0]  blk_q, blk_d;
	logic [hbac_pkg::KEY_W-1:0]  pend_key_q, pend_key_d;
	logic [hbac_pkg::CNT_W-1:0]  pend_cnt_q, pend_cnt_d;
	hbac_pkg::res_t              resp_q, resp_d;

	logic key_lt, key_eq, is_hot, i_end, stop_hit, go;
	logic [hbac_pkg::CNT_W-1:0] cnt_inc;
	hbac_pkg::res_t done_res;

	assign key_lt   = rd_key < blk_q;
	assign key_eq   = rd_key == blk_q;
	assign is_hot   = rd_cnt >= thresh;
	assign cnt_inc  = (rd_cnt == hbac_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
	assign i_end    = (USED_W'(i_q) + USED_W'(1)) == used_q;
	assign stop_hit = is_hot && (fcnt_q == hbac_pkg::RES_W'(hbac_pkg::MAX_RESULTS - 1));
	assign done_res = '{status: hbac_pkg::ST_DONE, blk: '0, cnt: '0, last: 1'b1};

	always_comb begin
		state_d    = state_q;
		used_d     = used_q;
		i_d        = i_q;
		j_d        = j_q;
		pos_d      = pos_q;
		fcnt_d     = fcnt_q;
		pend_v_d   = pend_v_q;
		blk_d      = blk_q;
		pend_key_d = pend_key_q;
		pend_cnt_d = pend_cnt_q;
		resp_d     = resp_q;
		in_ready   = 1'b0;
		res_valid  = 1'b0;
		res        = resp_q;
		rd_en      = 1'b0;
		rd_addr    = i_q;
		wr_addr    = i_q;
		wr         = '0;
		go         = 1'b1;
		unique case (state_q)
			hbac_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					blk_d    = in_blk;
					i_d      = '0;
					fcnt_d   = '0;
					pend_v_d = 1'b0;
					pos_d    = '0;
					resp_d   = done_res;
					case (hbac_pkg::mode_t'(in_mode))
						hbac_pkg::MODE_RECORD: begin
							state_d = (used_q == '0) ? hbac_pkg::S_INS : hbac_pkg::S_REC_RD;
						end
						hbac_pkg::MODE_REPORT: begin
							if (used_q == '0) begin
								resp_d.status = hbac_pkg::ST_NOHOT;
								state_d       = hbac_pkg::S_RESP;
							end else begin
								state_d = hbac_pkg::S_REP_RD;
							end
						end
						hbac_pkg::MODE_CLEAR: begin
							state_d = (used_q == '0) ? hbac_pkg::S_RESP : hbac_pkg::S_CLR;
						end
						default: begin
							state_d = hbac_pkg::S_RESP;
						end
					endcase
				end
			end
			hbac_pkg::S_REC_RD: begin
				rd_en   = 1'b1;
				state_d = hbac_pkg::S_REC_CMP;
			end
			hbac_pkg::S_REC_CMP: begin
				if (key_eq) begin
					wr.cnt_we = 1'b1;
					wr.cnt    = cnt_inc;
					state_d   = hbac_pkg::S_RESP;
				end else if (key_lt && !i_end) begin
					i_d     = i_q + 1'b1;
					state_d = hbac_pkg::S_REC_RD;
				end else begin
					pos_d   = key_lt ? i_q + 1'b1 : i_q;
					state_d = hbac_pkg::S_INS;
				end
			end
			hbac_pkg::S_INS: begin
				if (used_q == USED_W'(TABLE_ENTRIES)) begin
					resp_d.status = hbac_pkg::ST_FULL;
					state_d       = hbac_pkg::S_RESP;
				end else begin
					j_d     = IDX_W'(used_q);
					state_d = hbac_pkg::S_SHIFT;
				end
			end
			hbac_pkg::S_SHIFT: begin
				if (j_q == pos_q) begin
					wr_addr   = pos_q;
					wr.key_we = 1'b1;
					wr.cnt_we = 1'b1;
					wr.key    = blk_q;
					wr.cnt    = hbac_pkg::CNT_W'(1);
					used_d    = used_q + 1'b1;
					state_d   = hbac_pkg::S_RESP;
				end else begin
					state_d = hbac_pkg::S_SH_RD;
				end
			end
			hbac_pkg::S_SH_RD: begin
				rd_en   = 1'b1;
				rd_addr = j_q - 1'b1;
				state_d = hbac_pkg::S_SH_WR;
			end
			hbac_pkg::S_SH_WR: begin
				wr_addr   = j_q;
				wr.key_we = 1'b1;
				wr.cnt_we = 1'b1;
				wr.key    = rd_key;
				wr.cnt    = rd_cnt;
				j_d       = j_q - 1'b1;
				state_d   = hbac_pkg::S_SHIFT;
			end
			hbac_pkg::S_REP_RD: begin
				rd_en   = 1'b1;
				state_d = hbac_pkg::S_REP_CHK;
			end
			hbac_pkg::S_REP_CHK: begin
				if (is_hot && pend_v_q) begin
					res_valid = 1'b1;
					res       = '{status: hbac_pkg::ST_HOT, blk: pend_key_q,
					              cnt: pend_cnt_q, last: 1'b0};
					go        = res_ready;
				end
				if (go) begin
					if (is_hot) begin
						pend_key_d = rd_key;
						pend_cnt_d = rd_cnt;
						pend_v_d   = 1'b1;
						fcnt_d     = fcnt_q + 1'b1;
					end
					if (stop_hit || i_end) begin
						if (is_hot) begin
							resp_d = '{status: hbac_pkg::ST_HOT, blk: rd_key,
							           cnt: rd_cnt, last: 1'b1};
						end else if (pend_v_q) begin
							resp_d = '{status: hbac_pkg::ST_HOT, blk: pend_key_q,
							           cnt: pend_cnt_q, last: 1'b1};
						end else begin
							resp_d = '{status: hbac_pkg::ST_NOHOT, blk: '0,
							           cnt: '0, last: 1'b1};
						end
						state_d = hbac_pkg::S_RESP;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = hbac_pkg::S_REP_RD;
					end
				end
			end
			hbac_pkg::S_CLR: begin
				wr.cnt_we = 1'b1;
				wr.cnt    = '0;
				if (i_end) begin
					state_d = hbac_pkg::S_RESP;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			hbac_pkg::S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = hbac_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hbac_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hbac_pkg::S_IDLE;
			used_q   <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			used_q   <= used_d;
			pend_v_q <= pend_v_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q        <= i_d;
		j_q        <= j_d;
		pos_q      <= pos_d;
		fcnt_q     <= fcnt_d;
		blk_q      <= blk_d;
		pend_key_q <= pend_key_d;
		pend_cnt_q <= pend_cnt_d;
		resp_q     <= resp_d;
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_ENTRIES))
		else $error("entry count beyond capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new beat taken while busy");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && res == $past(res)))
		else $error("stalled result changed");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.key_we || wr.cnt_we) |-> (USED_W'(wr_addr) <= used_q))
		else $error("write beyond used entries");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!res_valid && !wr.key_we && !wr.cnt_we))
		else $error("activity while idle");

endmodule

`default_nettype wire

// File: design/hot_block_access_counter.sv
// Hot block access counter: top level with threshold register and output register.
// Instantiates hbac_seq and hbac_table; depends on hbac_pkg.
//
// Input channel (in_valid/in_ready) carries mode and block_number; one beat is
// one request. Output channel (out_valid/out_ready) carries status, hot_block,
// access_count and last. in_ready is high only while the sequencer is idle.
// A record beat scans the table from the lowest entry, each entry compared
// through the store read port and then the shared key compare. A new block
// is then checked for room, each entry above the insert point is shifted up
// by a read and a write, and the new block is written. A report beat reads
// the used entries, stopping early once MAX_RESULTS hot entries are found,
// and gives one result per hot entry, or one no-hot result if none, the
// final one marked by last. A reset-all beat clears one count per cycle. Any
// other mode, or a report on an empty table, gives its single result in the
// cycle after acceptance; the next beat can be taken in the cycle after the
// final result leaves the sequencer. Results pass through an output register,
// so the next beat can be taken while a result waits; a stalled receiver
// holds the sequencer only when it has a further result to give.
// Reset empties the table and sets the threshold to 16; the store itself is
// not cleared. cfg_we writes cfg_wdata into the threshold at once.
`default_nettype none

module hot_block_access_counter #(
	parameter int TABLE_ENTRIES = hbac_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [hbac_pkg::CNT_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [hbac_pkg::MODE_W-1:0]   mode,
	input  wire logic [hbac_pkg::KEY_W-1:0]    block_number,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         status,
	output logic [hbac_pkg::KEY_W-1:0]         hot_block,
	output logic [hbac_pkg::CNT_W-1:0]         access_count,
	output logic                               last
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	logic [hbac_pkg::CNT_W-1:0] thresh_q;
	logic                       out_valid_q;
	hbac_pkg::res_t             out_q;
	logic                       res_valid, res_ready;
	hbac_pkg::res_t             res;
	logic                       rd_en;
	logic [IDX_W-1:0]           rd_addr, wr_addr;
	hbac_pkg::mem_wr_t          wr;
	logic [hbac_pkg::KEY_W-1:0] rd_key;
	logic [hbac_pkg::CNT_W-1:0] rd_cnt;

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q    <= hbac_pkg::THRESH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign hot_block    = out_q.blk;
	assign access_count = out_q.cnt;
	assign last         = out_q.last;

	hbac_seq #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_mode   (mode),
		.in_blk    (block_number),
		.thresh    (thresh_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr        (wr),
		.rd_key    (rd_key),
		.rd_cnt    (rd_cnt)
	);

	hbac_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr      (wr),
		.rd_key  (rd_key),
		.rd_cnt  (rd_cnt)
	);

endmodule

`default_nettype wire
